@@ rtl/core/sigc_pkg.sv @@
// ============================================================================
// sigc_pkg : shared types and constants of the spiral-to-grid converter
// Field widths, sequencer states and the records passed between the
// square-root unit, the walk unit and the top level.
// ============================================================================
package sigc_pkg;

  // Field widths
  localparam int SIDE_W     = 17;
  localparam int POS_W      = 34;
  localparam int ROOT_W     = POS_W / 2;      // floor sqrt of a POS_W-bit value
  localparam int REM_W      = ROOT_W + 1;     // remainder never exceeds 2*root
  localparam int WALK_W     = ROOT_W + 3;     // offsets up to 4*root+3
  localparam int SQRT_STEPS = POS_W / 2;      // one radix-4 digit per cycle
  localparam int CNT_W      = $clog2(SQRT_STEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOT,
    ST_WALK
  } top_state_e;

  typedef enum logic [2:0] {
    WK_IDLE,
    WK_FIX,
    WK_SEG,
    WK_SEL,
    WK_OUT
  } walk_state_e;

  // Leg of the spiral ring that holds the cell
  typedef enum logic [2:0] {
    SEG_CORNER,
    SEG_UP,
    SEG_LEFT,
    SEG_DOWN,
    SEG_RIGHT
  } seg_e;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic [REM_W-1:0]  rem;
  } sqrt_res_t;

  typedef struct packed {
    logic [SIDE_W-1:0] line;
    logic [SIDE_W-1:0] column;
    logic              oor;
  } walk_res_t;

endpackage

@@ rtl/core/sigc_isqrt.sv @@
// ============================================================================
// sigc_isqrt : digit-serial integer square root
// Shifts the radicand in two bits per cycle and settles one root bit per
// cycle; the remainder comes out alongside the root.
// ============================================================================
module sigc_isqrt
  import sigc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [POS_W-1:0] radicand_i,
  output logic             done_o,
  output sqrt_res_t        res_o
);

  logic              busy_q, busy_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [POS_W-1:0]  rad_q, rad_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;

  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  diff;
  logic              take;

  assign rem_sh = {rem_q, rad_q[POS_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign take   = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(SQRT_STEPS - 1);
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d  = {rad_q[POS_W-3:0], 2'b00};
      rem_d  = take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_d = {root_q[ROOT_W-2:0], take};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o    = busy_q && (cnt_q == '0);
  assign res_o.root = root_q;
  assign res_o.rem  = rem_q;

endmodule

@@ rtl/core/sigc_walk.sv @@
// ============================================================================
// sigc_walk : ring leg selection and coordinate arithmetic
// Turns root and remainder into the odd ring root and the offset along the
// ring, picks the leg and forms line and column.
// ============================================================================
module sigc_walk
  import sigc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              take_i,
  input  logic [SIDE_W-1:0] side_i,
  input  logic              pos_zero_i,
  input  sqrt_res_t         sqrt_i,
  output logic              done_o,
  output walk_res_t         res_o
);

  walk_state_e state_q, state_d;

  logic [ROOT_W-1:0] r_q;
  logic [WALK_W-1:0] d_q, base_q, t1_q, t2_q, t3_q, t4_q;
  logic              oor_q;
  seg_e              seg_q, seg_d;

  logic              q_even;
  logic [ROOT_W-1:0] r_d;
  logic [WALK_W-1:0] d_d, base_d;
  logic              oor_d;
  logic [SIDE_W:0]   side_p1;
  logic [WALK_W-1:0] r_w;
  logic [WALK_W-1:0] line_w, col_w;

  // Step back to an odd root when the floor root is even.
  assign q_even  = ~sqrt_i.root[0];
  assign side_p1 = {1'b0, side_i} + 1'b1;
  assign r_d     = q_even ? sqrt_i.root - 1'b1 : sqrt_i.root;
  assign d_d     = q_even ? WALK_W'(sqrt_i.rem) + WALK_W'({sqrt_i.root, 1'b0}) - 1'b1
                          : WALK_W'(sqrt_i.rem);
  assign base_d  = WALK_W'(side_p1[SIDE_W:1]) + WALK_W'(sqrt_i.root[ROOT_W-1:1])
                   - WALK_W'(q_even);
  assign oor_d   = pos_zero_i || (side_i == '0) || (sqrt_i.root > side_i)
                   || ((sqrt_i.root == side_i) && (sqrt_i.rem != '0));
  assign r_w     = WALK_W'(r_q);

  always_comb begin
    state_d = state_q;
    seg_d   = seg_q;
    done_o  = 1'b0;
    case (state_q)
      WK_IDLE: begin
        if (start_i) begin
          state_d = WK_FIX;
        end
      end
      WK_FIX: state_d = WK_SEG;
      WK_SEG: state_d = WK_SEL;
      WK_SEL: begin
        if (d_q == '0) begin
          seg_d = SEG_CORNER;
        end else if (d_q <= t1_q) begin
          seg_d = SEG_UP;
        end else if (d_q <= t2_q) begin
          seg_d = SEG_LEFT;
        end else if (d_q <= t3_q) begin
          seg_d = SEG_DOWN;
        end else begin
          seg_d = SEG_RIGHT;
        end
        state_d = WK_OUT;
      end
      WK_OUT: begin
        done_o = 1'b1;
        if (take_i) begin
          state_d = WK_IDLE;
        end
      end
      default: state_d = WK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= WK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q <= seg_d;
    if (state_q == WK_FIX) begin
      r_q    <= r_d;
      d_q    <= d_d;
      base_q <= base_d;
      oor_q  <= oor_d;
    end
    if (state_q == WK_SEG) begin
      t1_q <= r_w + 1'b1;
      t2_q <= {r_w[WALK_W-2:0], 1'b0} + WALK_W'(2);
      t3_q <= {r_w[WALK_W-2:0], 1'b0} + r_w + WALK_W'(3);
      t4_q <= {r_w[WALK_W-3:0], 2'b00} + WALK_W'(3);
    end
  end

  // Leg offsets from the corner cell that holds root squared
  always_comb begin
    case (seg_q)
      SEG_CORNER: begin
        line_w = base_q;
        col_w  = base_q;
      end
      SEG_UP: begin
        line_w = base_q + 1'b1;
        col_w  = base_q + 1'b1 - d_q;
      end
      SEG_LEFT: begin
        line_w = base_q + t1_q + 1'b1 - d_q;
        col_w  = base_q - r_w;
      end
      SEG_DOWN: begin
        line_w = base_q - r_w;
        col_w  = base_q + d_q + 1'b1 - t3_q;
      end
      SEG_RIGHT: begin
        line_w = base_q + d_q - t4_q;
        col_w  = base_q + 1'b1;
      end
      default: begin
        line_w = base_q;
        col_w  = base_q;
      end
    endcase
  end

  assign res_o.line   = oor_q ? '0 : line_w[SIDE_W-1:0];
  assign res_o.column = oor_q ? '0 : col_w[SIDE_W-1:0];
  assign res_o.oor    = oor_q;

endmodule

@@ rtl/core/spiral_index_to_grid_coord_top.sv @@
// Sequence: the square-root unit settles the root digits, then the walk unit
//   steps through WK_FIX, WK_SEG, WK_SEL and WK_OUT; a stalled output holds it longer.
// Throughput: one item in flight at a time; the serial square-root unit, one
//   root bit per cycle over a 34-bit position, bounds the item rate.
// Reset: asynchronous, active low; clears the sequencers and result valid.
// ============================================================================
// spiral_index_to_grid_coord_top : square spiral index to grid coordinates
// Finds the odd ring holding a one-based spiral position and returns the
// line and column of the cell in a square grid, or flags it out of range.
// ============================================================================
module spiral_index_to_grid_coord_top
  import sigc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [SIDE_W-1:0] grid_side_i,
  input  logic [POS_W-1:0]  spiral_position_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [SIDE_W-1:0] line_o,
  output logic [SIDE_W-1:0] column_o,
  output logic              out_of_range_o
);

  top_state_e state_q, state_d;

  logic              in_xfer;
  logic              out_free;
  logic              sqrt_done;
  logic              walk_start;
  logic              walk_done;
  logic              walk_take;
  sqrt_res_t         sqrt_res;
  walk_res_t         walk_res;

  // Side and the zero-position flag stay put for the whole item.
  logic [SIDE_W-1:0] side_q;
  logic              pos_zero_q;

  logic              out_valid_q, out_valid_d;
  walk_res_t         out_q;

  // One item in flight: take a new one only when the sequencer is idle.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Output register is free when empty or being drained this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    walk_start  = 1'b0;
    walk_take   = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        // Hand root and remainder to the walk unit once the last digit lands.
        if (sqrt_done) begin
          walk_start = 1'b1;
          state_d    = ST_WALK;
        end
      end
      ST_WALK: begin
        // Hold the walk result until the output register can take it.
        if (walk_done && out_free) begin
          walk_take   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      side_q     <= grid_side_i;
      pos_zero_q <= (spiral_position_i == '0);
    end
    if (walk_take) begin
      out_q <= walk_res;
    end
  end

  sigc_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_xfer),
    .radicand_i (spiral_position_i),
    .done_o     (sqrt_done),
    .res_o      (sqrt_res)
  );

  sigc_walk u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (walk_start),
    .take_i     (walk_take),
    .side_i     (side_q),
    .pos_zero_i (pos_zero_q),
    .sqrt_i     (sqrt_res),
    .done_o     (walk_done),
    .res_o      (walk_res)
  );

  assign out_valid_o    = out_valid_q;
  assign line_o         = out_q.line;
  assign column_o       = out_q.column;
  assign out_of_range_o = out_q.oor;

  // The root unit finishes only while the sequencer waits for it.
  a_root_done_in_root : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> (state_q == ST_ROOT))
    else $error("square root finished outside the root phase");

  // A walk result is offered only while the sequencer waits for it.
  a_walk_done_in_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_done |-> (state_q == ST_WALK))
    else $error("walk result offered outside the walk phase");

  // An out-of-range result carries zero coordinates.
  a_oor_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_of_range_o) |-> ((line_o == '0) && (column_o == '0)))
    else $error("out-of-range result with nonzero coordinates");

  // A result is loaded only into a free output register.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !walk_take)
    else $error("stalled result overwritten");

endmodule
